// File: sv/rde_pkg.sv
// ----------------------------------------------------------------------------
// Reversible deque engine package
// Shared constants, item types and the ring-buffer slot function.
// ----------------------------------------------------------------------------
package rde_pkg;

    localparam int DEPTH = 64;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int VAL_W = 8;

    localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(DEPTH);
    localparam logic [SUM_W-1:0] SUM_DEPTH = SUM_W'(DEPTH);

    typedef enum logic [1:0] {
        ACT_LOAD    = 2'd0,
        ACT_REVERSE = 2'd1,
        ACT_DROP    = 2'd2,
        ACT_DRAIN   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_ELEMENT  = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_ERROR    = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    typedef struct packed {
        t_action            action;
        logic [VAL_W-1:0]   value;
    } t_in;

    typedef struct packed {
        logic [VAL_W-1:0]   value_res;
        t_status            status;
        logic               last;
    } t_out;

    // Classified command passed from the front queue to the back end.
    typedef struct packed {
        logic               is_load;
        logic               is_rev;
        logic               is_drop;
        logic               is_drain;
        logic [VAL_W-1:0]   value;
    } t_cmd;

    // Back-end status seen by the top level.
    typedef struct packed {
        logic               draining;
        logic [CNT_W-1:0]   count;
    } t_bk_stat;

    // Physical slot of a logical offset from the head. The sum stays below
    // twice the depth, so one compare and subtract wraps it.
    function automatic logic [PTR_W-1:0] rde_slot(input logic [PTR_W-1:0] head,
                                                  input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(off);
        if (sum >= SUM_DEPTH) begin
            sum = sum - SUM_DEPTH;
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

// File: sv/rde_front.sv
// ----------------------------------------------------------------------------
// Reversible deque engine front end
// Accepts input items, decodes the action and holds them in a short queue.
// ----------------------------------------------------------------------------
module rde_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  rde_pkg::t_in    i_item,
    output logic            o_cmd_valid,
    output rde_pkg::t_cmd   o_cmd,
    input  logic            i_pop
);

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
    localparam logic [Q_CNT_W-1:0] Q_FULL = Q_CNT_W'(Q_DEPTH);

    rde_pkg::t_cmd        r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr;
    logic [Q_PTR_W-1:0]   r_rd;
    logic [Q_CNT_W-1:0]   r_cnt;
    rde_pkg::t_cmd        n_cmd;
    logic                 push;
    logic                 pop;

    assign o_stall     = (r_cnt == Q_FULL);
    assign push        = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != '0);
    assign pop         = i_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rd];

    always_comb begin
        n_cmd       = '0;
        n_cmd.value = i_item.value;
        case (i_item.action)
            rde_pkg::ACT_LOAD:    n_cmd.is_load  = 1'b1;
            rde_pkg::ACT_REVERSE: n_cmd.is_rev   = 1'b1;
            rde_pkg::ACT_DROP:    n_cmd.is_drop  = 1'b1;
            rde_pkg::ACT_DRAIN:   n_cmd.is_drain = 1'b1;
            default:              n_cmd.is_drain = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= n_cmd;
        end
    end

endmodule

// File: sv/rde_back.sv
// ----------------------------------------------------------------------------
// Reversible deque engine back end
// Ring-buffer storage, pointer updates and the drain sequencer.
// ----------------------------------------------------------------------------
module rde_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  rde_pkg::t_cmd       i_cmd,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output rde_pkg::t_out       o_res,
    output rde_pkg::t_bk_stat   o_stat
);

    typedef enum logic {
        S_IDLE,
        S_DRAIN
    } t_state;

    logic [rde_pkg::VAL_W-1:0]  mem [rde_pkg::DEPTH];

    t_state                     r_state, n_state;
    logic [rde_pkg::PTR_W-1:0]  r_head, n_head;
    logic [rde_pkg::CNT_W-1:0]  r_count, n_count;
    logic                       r_rev, n_rev;
    logic                       r_err, n_err;
    logic                       r_ovf, n_ovf;
    logic [rde_pkg::PTR_W-1:0]  r_idx, n_idx;
    logic                       r_rd_vld, n_rd_vld;
    rde_pkg::t_out              r_rd_res;
    logic                       r_out_vld, n_out_vld;
    rde_pkg::t_out              r_out_res, n_out_res;

    logic                       rd_move;
    logic                       rd_free;
    logic                       cmd_go;
    logic                       issue_elem;
    logic                       issue_stat;
    rde_pkg::t_status           stat_code;
    logic [rde_pkg::CNT_W-1:0]  idx_ext;
    logic [rde_pkg::CNT_W-1:0]  off;
    logic [rde_pkg::PTR_W-1:0]  rd_addr;
    logic                       elem_last;
    logic                       mem_we;
    logic [rde_pkg::PTR_W-1:0]  mem_waddr;

    // The read stage empties into the output register when that one is free
    // or being taken, so a drain streams one element per cycle while unstalled.
    assign rd_move = r_rd_vld && (!r_out_vld || !i_stall);
    assign rd_free = !r_rd_vld || rd_move;
    assign idx_ext = rde_pkg::CNT_W'(r_idx);
    assign off     = r_rev ? (r_count - 1'b1 - idx_ext) : idx_ext;
    assign rd_addr = rde_pkg::rde_slot(r_head, off);
    assign elem_last = (idx_ext == (r_count - 1'b1));
    assign mem_waddr = rde_pkg::rde_slot(r_head, r_count);

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_count    = r_count;
        n_rev      = r_rev;
        n_err      = r_err;
        n_ovf      = r_ovf;
        n_idx      = r_idx;
        cmd_go     = 1'b0;
        issue_elem = 1'b0;
        issue_stat = 1'b0;
        stat_code  = rde_pkg::ST_EMPTY;
        mem_we     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.is_drain) begin
                        if (rd_free) begin
                            cmd_go = 1'b1;
                            if (r_err) begin
                                issue_stat = 1'b1;
                                stat_code  = rde_pkg::ST_ERROR;
                            end else if (r_ovf) begin
                                issue_stat = 1'b1;
                                stat_code  = rde_pkg::ST_OVERFLOW;
                            end else if (r_count == '0) begin
                                issue_stat = 1'b1;
                                stat_code  = rde_pkg::ST_EMPTY;
                            end else begin
                                n_state = S_DRAIN;
                                n_idx   = '0;
                            end
                        end
                    end else begin
                        cmd_go = 1'b1;
                        if (i_cmd.is_load) begin
                            if (r_count == rde_pkg::CNT_DEPTH) begin
                                n_ovf = 1'b1;
                            end else begin
                                mem_we  = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        if (i_cmd.is_rev) begin
                            n_rev = !r_rev;
                        end
                        if (i_cmd.is_drop && !r_err) begin
                            if (r_count == '0) begin
                                n_err = 1'b1;
                            end else begin
                                // A reversed view drops from the back, which
                                // leaves the head where it is.
                                if (!r_rev) begin
                                    n_head = rde_pkg::rde_slot(r_head,
                                                               rde_pkg::CNT_W'(1));
                                end
                                n_count = r_count - 1'b1;
                            end
                        end
                    end
                end
            end
            S_DRAIN: begin
                if (rd_free) begin
                    issue_elem = 1'b1;
                    n_idx      = r_idx + 1'b1;
                    if (elem_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Every drain ends by clearing the run.
        if (issue_stat || (issue_elem && elem_last)) begin
            n_head  = '0;
            n_count = '0;
            n_rev   = 1'b0;
            n_err   = 1'b0;
            n_ovf   = 1'b0;
        end
    end

    always_comb begin
        n_rd_vld  = r_rd_vld;
        n_out_vld = r_out_vld;
        n_out_res = r_out_res;
        if (issue_elem || issue_stat) begin
            n_rd_vld = 1'b1;
        end else if (rd_move) begin
            n_rd_vld = 1'b0;
        end
        if (rd_move) begin
            n_out_vld = 1'b1;
            n_out_res = r_rd_res;
        end else if (r_out_vld && !i_stall) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_rev     <= 1'b0;
            r_err     <= 1'b0;
            r_ovf     <= 1'b0;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_out_res <= '0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_count   <= n_count;
            r_rev     <= n_rev;
            r_err     <= n_err;
            r_ovf     <= n_ovf;
            r_idx     <= n_idx;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
            r_out_res <= n_out_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= i_cmd.value;
        end
        if (issue_elem) begin
            r_rd_res <= '{value_res: mem[rd_addr], status: rde_pkg::ST_ELEMENT,
                          last: elem_last};
        end else if (issue_stat) begin
            r_rd_res <= '{value_res: '0, status: stat_code, last: 1'b1};
        end
    end

    assign o_pop           = cmd_go;
    assign o_valid         = r_out_vld;
    assign o_res           = r_out_res;
    assign o_stat.draining = (r_state == S_DRAIN);
    assign o_stat.count    = r_count;

endmodule

// File: sv/reversible_deque_engine_unit.sv
// ----------------------------------------------------------------------------
// Reversible deque engine
// Ring-buffer double-ended queue with a lazy reverse view and drain output.
// ----------------------------------------------------------------------------
// Items enter a four-entry command queue and are carried out by the back end
// one at a time. A drain of elements first starts and then reads them one at
// a time through the single read port of the 64-entry storage memory; its
// elements leave one per cycle while the output is not stalled. Input items
// keep being accepted into the queue during a drain until it fills. Status
// results and drain elements both pass through a read stage and an output
// register.
module reversible_deque_engine_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  rde_pkg::t_in    i_item,
    output logic            o_valid,
    input  logic            i_stall,
    output rde_pkg::t_out   o_res
);

    logic                   cmd_valid;
    rde_pkg::t_cmd          cmd;
    logic                   cmd_pop;
    rde_pkg::t_bk_stat      bk_stat;

    rde_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_item      (i_item),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_pop       (cmd_pop)
    );

    rde_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_pop       (cmd_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_res       (o_res),
        .o_stat      (bk_stat)
    );

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bk_stat.count <= rde_pkg::CNT_DEPTH)
        else $error("element count exceeds buffer depth");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.status != rde_pkg::ST_ELEMENT) |->
            (o_res.last && o_res.value_res == '0))
        else $error("status result without last mark or with nonzero value");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> cmd_valid)
        else $error("back end popped an empty command queue");

    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bk_stat.draining |-> (bk_stat.count != '0))
        else $error("drain running on an empty queue");

endmodule

// File: dv/tb_reversible_deque_engine_unit.sv
// ----------------------------------------------------------------------------
// Testbench for the reversible deque engine
// Drives load, reverse, drop and drain items into the engine with random gaps
// on both sides. A scoreboard mirrors the ring buffer, view direction and
// sticky flags, and checks every drain result in order as it leaves the block.
// ----------------------------------------------------------------------------
module tb_reversible_deque_engine_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_PCT     = 24;
    localparam int RANDOM_ITEMS = 360;
    localparam int HOLD_CYCLES  = 160;
    localparam int EXP_SLOTS    = 4096;

    // Mirror of the deque state and the results its drains must produce.
    class deque_scoreboard;
        rde_pkg::t_out             exp_buf[EXP_SLOTS];
        int unsigned               exp_wr;
        int unsigned               exp_rd;
        logic [rde_pkg::VAL_W-1:0] cells[rde_pkg::DEPTH];
        int unsigned               head;
        int unsigned               fill;
        bit                        reversed;
        bit                        err_flag;
        bit                        ovf_flag;
        int                        errors;

        function new();
            errors = 0;
            exp_wr = 0;
            exp_rd = 0;
            restart();
        endfunction

        function void restart();
            head     = 0;
            fill     = 0;
            reversed = 1'b0;
            err_flag = 1'b0;
            ovf_flag = 1'b0;
        endfunction

        function int unsigned pending();
            return exp_wr - exp_rd;
        endfunction

        function void add_expected(rde_pkg::t_out r);
            exp_buf[exp_wr % EXP_SLOTS] = r;
            exp_wr++;
        endfunction

        // Applies one accepted item. Returns 0 when the block ignores it.
        function bit note_item(rde_pkg::t_in item);
            rde_pkg::t_out r;
            case (item.action)
                rde_pkg::ACT_LOAD: begin
                    if (fill >= rde_pkg::DEPTH) begin
                        ovf_flag = 1'b1;
                    end else begin
                        cells[(head + fill) % rde_pkg::DEPTH] = item.value;
                        fill++;
                    end
                end
                rde_pkg::ACT_REVERSE: begin
                    reversed = !reversed;
                end
                rde_pkg::ACT_DROP: begin
                    if (err_flag) begin
                        return 1'b0;
                    end
                    if (fill == 0) begin
                        err_flag = 1'b1;
                    end else begin
                        // A reversed view drops from the physical back.
                        if (!reversed) begin
                            head = (head + 1) % rde_pkg::DEPTH;
                        end
                        fill--;
                    end
                end
                default: begin
                    if (err_flag || ovf_flag || fill == 0) begin
                        r.value_res = '0;
                        r.status    = err_flag ? rde_pkg::ST_ERROR :
                                      (ovf_flag ? rde_pkg::ST_OVERFLOW : rde_pkg::ST_EMPTY);
                        r.last      = 1'b1;
                        add_expected(r);
                    end else begin
                        for (int i = 0; i < fill; i++) begin
                            r.value_res = cells[(head + (reversed ? fill - 1 - i : i))
                                                % rde_pkg::DEPTH];
                            r.status    = rde_pkg::ST_ELEMENT;
                            r.last      = (i == fill - 1);
                            add_expected(r);
                        end
                    end
                    restart();
                end
            endcase
            return 1'b1;
        endfunction

        function void check_result(rde_pkg::t_out got);
            rde_pkg::t_out want;
            if (pending() == 0) begin
                errors++;
                $display("t=%0t: unexpected result value=%02h status=%0d last=%b",
                         $time, got.value_res, got.status, got.last);
                return;
            end
            want = exp_buf[exp_rd % EXP_SLOTS];
            exp_rd++;
            if (got.value_res !== want.value_res || got.status !== want.status ||
                got.last !== want.last) begin
                errors++;
                $display("%0t: expected val=%02h st=%0d last=%b, actual val=%02h st=%0d last=%b",
                         $time, want.value_res, want.status, want.last,
                         got.value_res, got.status, got.last);
            end
        endfunction
    endclass

    logic           i_clk   = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_valid = 1'b0;
    logic           i_stall = 1'b0;
    rde_pkg::t_in   i_item  = '0;
    logic           o_stall;
    logic           o_valid;
    rde_pkg::t_out  o_res;

    deque_scoreboard sb = new();

    int in_idle_pct  = IDLE_PCT;
    int out_idle_pct = IDLE_PCT;
    int live_items   = 0;
    bit hold_req     = 1'b0;

    reversible_deque_engine_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (o_res)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Offers one item and returns at the edge where it is accepted.
    task automatic send_item(input rde_pkg::t_action act,
                             input logic [rde_pkg::VAL_W-1:0] val);
        rde_pkg::t_in item;
        item.action = act;
        item.value  = val;
        if ($urandom_range(0, 99) < in_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < in_idle_pct);
        end
        i_valid <= 1'b1;
        i_item  <= item;
        do @(posedge i_clk); while (o_stall);
        if (sb.note_item(item)) begin
            live_items++;
        end
    endtask

    // Walks the head forward unless a leading drop set the error, then loads the
    // buffer to full or past it, so the live elements wrap around the storage end.
    task automatic fill_run(input bit spill, input bit bad_drop);
        int shift;
        int extra;
        shift = $urandom_range(1, 12);
        extra = spill ? $urandom_range(1, 4) : 0;
        if (bad_drop) begin
            send_item(rde_pkg::ACT_DROP, 8'($urandom));
        end
        repeat (shift) begin
            send_item(rde_pkg::ACT_LOAD, 8'($urandom));
            send_item(rde_pkg::ACT_DROP, 8'($urandom));
        end
        repeat (rde_pkg::DEPTH + extra) begin
            if ($urandom_range(0, 31) == 0) begin
                send_item(rde_pkg::ACT_REVERSE, 8'($urandom));
            end
            send_item(rde_pkg::ACT_LOAD, 8'($urandom));
        end
        send_item(rde_pkg::ACT_DRAIN, 8'($urandom));
    endtask

    // A short run of loads, reverses and drops closed by a drain.
    task automatic mixed_run();
        int len;
        int pick;
        len = $urandom_range(1, 14);
        repeat (len) begin
            pick = $urandom_range(0, 99);
            if (pick < 58) begin
                send_item(rde_pkg::ACT_LOAD, 8'($urandom));
            end else if (pick < 76) begin
                send_item(rde_pkg::ACT_REVERSE, 8'($urandom));
            end else begin
                send_item(rde_pkg::ACT_DROP, 8'($urandom));
            end
        end
        send_item(rde_pkg::ACT_DRAIN, 8'($urandom));
    endtask

    // Receiver side: random stalls, plus one long hold-off on request.
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(0, 99) < out_idle_pct);
            end
        end
    end

    initial begin : result_check
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                sb.check_result(o_res);
            end
        end
    end

    initial begin : stimulus
        int  pick;
        int  guard;
        bit  quiet_done;
        quiet_done = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty drain, drop on empty, drop while in error, load and
        // reverse while in error, drops from both ends, toggled views.
        send_item(rde_pkg::ACT_DRAIN, 8'h00);
        send_item(rde_pkg::ACT_DROP, 8'hFF);
        send_item(rde_pkg::ACT_DROP, 8'h00);
        send_item(rde_pkg::ACT_LOAD, 8'h00);
        send_item(rde_pkg::ACT_REVERSE, 8'hFF);
        send_item(rde_pkg::ACT_DRAIN, 8'hFF);
        send_item(rde_pkg::ACT_LOAD, 8'hFF);
        send_item(rde_pkg::ACT_LOAD, 8'h00);
        send_item(rde_pkg::ACT_LOAD, 8'hA5);
        send_item(rde_pkg::ACT_DROP, 8'h00);
        send_item(rde_pkg::ACT_REVERSE, 8'h00);
        send_item(rde_pkg::ACT_LOAD, 8'h5A);
        send_item(rde_pkg::ACT_DROP, 8'h00);
        send_item(rde_pkg::ACT_DRAIN, 8'h00);
        send_item(rde_pkg::ACT_LOAD, 8'h01);
        send_item(rde_pkg::ACT_REVERSE, 8'h00);
        send_item(rde_pkg::ACT_REVERSE, 8'h00);
        send_item(rde_pkg::ACT_DRAIN, 8'h00);
        send_item(rde_pkg::ACT_LOAD, 8'h80);
        send_item(rde_pkg::ACT_DROP, 8'h00);
        send_item(rde_pkg::ACT_DRAIN, 8'h00);
        send_item(rde_pkg::ACT_LOAD, 8'h7F);
        send_item(rde_pkg::ACT_REVERSE, 8'h00);
        send_item(rde_pkg::ACT_DRAIN, 8'h00);

        // Random: a full buffer, an overflow, and an overflow behind an
        // error, then mostly short well-formed runs with some noise.
        live_items = 0;
        fill_run(1'b0, 1'b0);
        fill_run(1'b1, 1'b0);
        fill_run(1'b1, 1'b1);
        while (live_items < RANDOM_ITEMS) begin
            if (!quiet_done && live_items >= 260) begin
                // No idling here; the receiver holds off so the block backs up.
                quiet_done   = 1'b1;
                in_idle_pct  = 0;
                out_idle_pct = 0;
                hold_req     = 1'b1;
                repeat (8) mixed_run();
                in_idle_pct  = IDLE_PCT;
                out_idle_pct = IDLE_PCT;
            end
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                fill_run(1'($urandom), 1'($urandom));
            end else if (pick < 17) begin
                repeat ($urandom_range(1, 8)) begin
                    send_item(rde_pkg::t_action'(2'($urandom_range(0, 3))), 8'($urandom));
                end
            end else begin
                mixed_run();
            end
        end
        send_item(rde_pkg::ACT_DRAIN, 8'($urandom));
        i_valid <= 1'b0;

        guard = 0;
        while (sb.pending() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
        if (sb.pending() != 0) begin
            sb.errors++;
            $display("t=%0t: %0d expected results never arrived", $time,
                     sb.pending());
        end
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
